### src/bbsr_pkg.sv
`timescale 1ns / 1ps

package bbsr_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SEQ_LENGTH    = 2'd0;
  localparam logic [1:0] REG_BALANCE_BOUND = 2'd1;
  localparam logic [1:0] REG_MODULUS       = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_ROW0,
    ST_ROW_START,
    ST_RD,
    ST_WR,
    ST_READY,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic row0_wr;
    logic row_start;
    logic rd;
    logic wr;
    logic sym_take;
    logic sym_upd;
    logic fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row0_end;
    logic col_end;
    logic row_end;
    logic last_sym;
    logic out_busy;
  } sts_t;

  // Modular sum of two residues that are both below the modulus.
  function automatic logic [31:0] mod_add(input logic [31:0] a, input logic [31:0] b,
                                          input logic [32:0] m);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[31:0];
  endfunction

endpackage

### src/bounded_balance_sequence_rank.sv
`timescale 1ns / 1ps

// Enumerative ranker for L/R sequences whose running balance (L = +1, R = -1) must stay
// within plus or minus balance_bound. After a reset or any write to a register in range,
// the block rebuilds its table of valid-completion counts modulo the modulus, and any
// sequence in progress is dropped. The build is paced by the one read port and one write
// port of the table memory: row 0 is written directly, and each further row is worked
// out entry by entry, each a read of the row before and then a write. in_stall is high
// throughout the build. Afterwards each accepted symbol is followed by one table read
// and one modular add before the next is taken; a sequence's last symbol then passes a
// finish state that forms the result, held there only while the previous result is still
// stalled in the output register. A result transfer carries the number of valid sequences
// not greater than the input, taking L before R and counting the input when it is valid,
// together with a flag that tells whether the input stayed within the bound. Once the
// balance has left the bound, the remaining symbols are still counted but add nothing.
// Registers: seq_length at byte address 0 (0 is read as 1, values above MAX_LEN as
// MAX_LEN), balance_bound at 4 (values above MAX_BOUND clamp to MAX_BOUND) and modulus
// at 8 (0 stands for 2^32). Writes should be made only while the block is idle.

module bounded_balance_sequence_rank
  import bbsr_pkg::*;
#(
  parameter int MAX_LEN   = 64,
  parameter int MAX_BOUND = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_rank_count,
  output logic        out_sequence_valid,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int K_W   = $clog2(MAX_BOUND + 1);

  logic             cfg_wr;
  logic [LEN_W-1:0] n_eff;
  logic [K_W-1:0]   k_eff;
  logic [32:0]      m33;
  cmd_t             cmd;
  sts_t             sts;

  // Register file: holds the raw settings and presents them in clamped form.
  bbsr_regs #(
    .MAX_LEN   (MAX_LEN),
    .MAX_BOUND (MAX_BOUND)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_wr      (cfg_wr),
    .n_eff       (n_eff),
    .k_eff       (k_eff),
    .m33         (m33)
  );

  // The controller sequences the table build and then the per-symbol lookups.
  bbsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table memory, the build window, the running sequence state
  // and the output register.
  bbsr_dp #(
    .MAX_LEN   (MAX_LEN),
    .MAX_BOUND (MAX_BOUND)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .n_eff              (n_eff),
    .k_eff              (k_eff),
    .m33                (m33),
    .in_symbol          (in_symbol),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_rank_count     (out_rank_count),
    .out_sequence_valid (out_sequence_valid)
  );

endmodule

### src/bbsr_regs.sv
`timescale 1ns / 1ps

module bbsr_regs
  import bbsr_pkg::*;
#(
  parameter int MAX_LEN   = 64,
  parameter int MAX_BOUND = 8,
  localparam int LEN_W = $clog2(MAX_LEN + 1),
  localparam int K_W   = $clog2(MAX_BOUND + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [3:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic             cfg_wr,
  output logic [LEN_W-1:0] n_eff,
  output logic [K_W-1:0]   k_eff,
  output logic [32:0]      m33
);

  logic [6:0]  seq_length_r;
  logic [3:0]  balance_bound_r;
  logic [31:0] modulus_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_wr     = wr_en && (idx == REG_SEQ_LENGTH || idx == REG_BALANCE_BOUND ||
                                idx == REG_MODULUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_length_r    <= 7'd64;
      balance_bound_r <= 4'd2;
      modulus_r       <= 32'd1000000;
    end else if (wr_en) begin
      case (idx)
        REG_SEQ_LENGTH:    seq_length_r    <= cfg_pwdata[6:0];
        REG_BALANCE_BOUND: balance_bound_r <= cfg_pwdata[3:0];
        REG_MODULUS:       modulus_r       <= cfg_pwdata;
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEQ_LENGTH:    cfg_prdata = {25'd0, seq_length_r};
      REG_BALANCE_BOUND: cfg_prdata = {28'd0, balance_bound_r};
      REG_MODULUS:       cfg_prdata = modulus_r;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // Clamp the raw settings to what the table can hold.
  always_comb begin
    if (seq_length_r == 7'd0) begin
      n_eff = LEN_W'(1);
    end else if (32'(seq_length_r) > 32'(MAX_LEN)) begin
      n_eff = LEN_W'(MAX_LEN);
    end else begin
      n_eff = LEN_W'(seq_length_r);
    end
    if (32'(balance_bound_r) > 32'(MAX_BOUND)) begin
      k_eff = K_W'(MAX_BOUND);
    end else begin
      k_eff = K_W'(balance_bound_r);
    end
    m33 = (modulus_r == 32'd0) ? {1'b1, 32'd0} : {1'b0, modulus_r};
  end

endmodule

### src/bbsr_ctrl.sv
`timescale 1ns / 1ps

module bbsr_ctrl
  import bbsr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:      state_nxt = ST_ROW0;
      ST_ROW0: begin
        if (sts.row0_end) begin
          state_nxt = sts.row_end ? ST_READY : ST_ROW_START;
        end
      end
      ST_ROW_START: state_nxt = ST_RD;
      ST_RD:        state_nxt = ST_WR;
      ST_WR: begin
        if (sts.col_end) begin
          state_nxt = sts.row_end ? ST_READY : ST_ROW_START;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_READY: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP:    state_nxt = sts.last_sym ? ST_FINISH : ST_READY;
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_nxt = ST_READY;
        end
      end
      default:      state_nxt = ST_INIT;
    endcase
    if (cfg_wr) begin
      state_nxt = ST_INIT;
    end
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_INIT:      cmd.init      = 1'b1;
      ST_ROW0:      cmd.row0_wr   = 1'b1;
      ST_ROW_START: cmd.row_start = 1'b1;
      ST_RD:        cmd.rd        = 1'b1;
      ST_WR:        cmd.wr        = 1'b1;
      ST_READY:     cmd.sym_take  = in_valid;
      ST_LOOKUP:    cmd.sym_upd   = 1'b1;
      ST_FINISH:    cmd.fin       = !sts.out_busy;
      default:      cmd           = '0;
    endcase
    if (cfg_wr) begin
      cmd = '0;
    end
  end

  assign in_stall = (state_r != ST_READY);

  a_take_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !cfg_wr) |=> (state_r == ST_LOOKUP))
    else $error("accepted symbol not followed by its table lookup");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (state_r == ST_INIT))
    else $error("register write did not restart the table build");

endmodule

### src/bbsr_dp.sv
`timescale 1ns / 1ps

module bbsr_dp
  import bbsr_pkg::*;
#(
  parameter int MAX_LEN   = 64,
  parameter int MAX_BOUND = 8,
  localparam int LEN_W = $clog2(MAX_LEN + 1),
  localparam int K_W   = $clog2(MAX_BOUND + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [LEN_W-1:0] n_eff,
  input  logic [K_W-1:0]   k_eff,
  input  logic [32:0]      m33,
  input  logic             in_symbol,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [31:0]      out_rank_count,
  output logic             out_sequence_valid
);

  localparam int COLS   = 2 * MAX_BOUND + 1;
  localparam int DEPTH  = MAX_LEN * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLS);
  localparam int J_W    = $clog2(COLS + 1);
  localparam int BAL_W  = $clog2(MAX_BOUND + 2) + 1;
  localparam int SW     = BAL_W + 1;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  logic [LEN_W-1:0] row_r;
  logic [J_W-1:0]   col_r;
  logic [31:0]      w1_r, w2_r;

  logic [LEN_W-1:0]        pos_r;
  logic signed [BAL_W-1:0] bal_r;
  logic [31:0]             part_r;
  logic                    sv_r;
  logic                    sym_r;

  logic        out_valid_r;
  logic [31:0] out_rank_r;
  logic        out_sv_r;

  logic [J_W-1:0]          states;
  logic [31:0]             one_mod;
  logic [31:0]             rdm;
  logic signed [SW-1:0]    ks, nk, nb, be;
  logic signed [BAL_W-1:0] bal_nxt;
  logic                    nb_in, add_ok, sv_nxt;
  logic [SW-1:0]           col_full;
  logic [COL_W-1:0]        col_lk;
  logic [LEN_W-1:0]        row_lk;
  logic [ADDR_W-1:0]       addr_lk, addr_brd, addr_bwr, raddr, waddr;
  logic [31:0]             wdata, part_nxt;
  logic                    we, re;

  assign states  = J_W'({k_eff, 1'b1});
  assign one_mod = (m33 == 33'd1) ? 32'd0 : 32'd1;

  // Build: the right neighbour beyond the last column counts as zero.
  assign rdm      = sts.col_end ? 32'd0 : rdata_r;
  assign addr_brd = ADDR_W'(row_r - LEN_W'(1)) * ADDR_W'(COLS) + ADDR_W'(col_r);
  assign addr_bwr = ADDR_W'(row_r) * ADDR_W'(COLS) + ADDR_W'(col_r - J_W'(1));

  // Ranking: completions after choosing L here, from balance plus one.
  always_comb begin
    ks       = SW'(k_eff);
    nk       = -ks;
    nb       = {bal_r[BAL_W-1], bal_r} + SW'(1);
    nb_in    = (nb <= ks) && (nb >= nk);
    col_full = nb_in ? SW'(nb + ks) : '0;
    col_lk   = col_full[COL_W-1:0];
    row_lk   = n_eff - LEN_W'(1) - pos_r;
    addr_lk  = ADDR_W'(row_lk) * ADDR_W'(COLS) + ADDR_W'(col_lk);
    add_ok   = sv_r && sym_r && (nb <= ks);
    part_nxt = add_ok ? mod_add(part_r, rdata_r, m33) : part_r;
    bal_nxt  = sym_r ? (bal_r - BAL_W'(1)) : (bal_r + BAL_W'(1));
    be       = {bal_nxt[BAL_W-1], bal_nxt};
    sv_nxt   = (be <= ks) && (be >= nk);
  end

  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(col_r);
    wdata = one_mod;
    if (cmd.row0_wr) begin
      we = 1'b1;
    end else if (cmd.wr && col_r != '0) begin
      we    = 1'b1;
      waddr = addr_bwr;
      wdata = mod_add(w2_r, rdm, m33);
    end
    re    = cmd.rd || cmd.sym_take;
    raddr = cmd.rd ? addr_brd : addr_lk;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Build counters and the two-entry window over the previous row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.init) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.row_start) begin
      row_r <= row_r + LEN_W'(1);
      col_r <= '0;
    end else if (cmd.row0_wr || cmd.wr) begin
      col_r <= col_r + J_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      w1_r <= 32'd0;
      w2_r <= 32'd0;
    end else if (cmd.wr) begin
      w2_r <= w1_r;
      w1_r <= rdm;
    end
    if (cmd.sym_take) begin
      sym_r <= in_symbol;
    end
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init || cmd.fin) begin
      pos_r  <= '0;
      bal_r  <= '0;
      part_r <= 32'd0;
      sv_r   <= 1'b1;
    end else if (cmd.sym_upd) begin
      pos_r  <= pos_r + LEN_W'(1);
      part_r <= part_nxt;
      if (sv_r) begin
        bal_r <= bal_nxt;
        sv_r  <= sv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_rank_r <= sv_r ? mod_add(part_r, 32'd1, m33) : part_r;
      out_sv_r   <= sv_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_rank_count     = out_rank_r;
  assign out_sequence_valid = out_sv_r;

  assign sts.row0_end = (col_r == states - J_W'(1));
  assign sts.col_end  = (col_r == states);
  assign sts.row_end  = (row_r == n_eff - LEN_W'(1));
  assign sts.last_sym = (pos_r == n_eff - LEN_W'(1));
  assign sts.out_busy = out_valid_r && out_stall;

  a_part_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sym_upd |=> ({1'b0, part_r} < m33))
    else $error("partial count left the residue range");

  a_valid_tracks_balance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sym_upd |=> (sv_r == (($signed({bal_r[BAL_W-1], bal_r}) <= $signed(SW'(k_eff))) &&
                              ($signed({bal_r[BAL_W-1], bal_r}) >= -$signed(SW'(k_eff))))))
    else $error("validity flag disagrees with the running balance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> !(out_valid_r && out_stall))
    else $error("result written over one that is still stalled");

endmodule

### test/bounded_balance_sequence_rank_test.sv
`timescale 1ns / 1ps

module bounded_balance_sequence_rank_test;
  import bbsr_pkg::*;

  localparam int MAX_LEN   = 64;
  localparam int MAX_BOUND = 8;
  localparam int COLS      = 2 * MAX_BOUND + 1;

  // Symbol codes on in_symbol.
  localparam logic SYM_L = 1'b0;
  localparam logic SYM_R = 1'b1;

  // An index past the last register; a write there must leave the block untouched.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_SYMBOLS = 550;
  localparam int LATENCY_SLACK  = 12;
  localparam int REPORT_LIMIT   = 10;
  localparam int CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic [31:0] rank;
    logic        ok;
  } rank_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_symbol = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rank_count;
  logic        out_sequence_valid;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bounded_balance_sequence_rank #(
    .MAX_LEN  (MAX_LEN),
    .MAX_BOUND(MAX_BOUND)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_symbol         (in_symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rank_count    (out_rank_count),
    .out_sequence_valid(out_sequence_valid),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  // Symbols waiting to be driven, and the rank results that the accepted symbols owe.
  logic         symbols_to_send[$];
  rank_result_t owed_ranks[$];
  rank_result_t oldest_rank;

  int symbols_queued = 0;
  int symbols_taken  = 0;
  int results_seen   = 0;
  int writes_done    = 0;
  int fault_count    = 0;
  int cycle_count    = 0;
  logic in_fire = 1'b0;

  // Idling schedule: the sender is eager and the receiver busy for the first 190 symbol
  // transfers, the other way round up to 380, and neither for the rest.
  int send_gap_pct;
  int recv_stall_pct;
  assign send_gap_pct   = (symbols_taken < 190) ? 8  : (symbols_taken < 380) ? 61 : 0;
  assign recv_stall_pct = (symbols_taken < 190) ? 61 : (symbols_taken < 380) ? 8  : 0;

  // ---------------------------------------------------------------------------------------
  // Rank predictor. It keeps its own copy of the registers, of the completion-count table
  // and of the sequence in progress, and mirrors the block one accepted symbol at a time.
  // ---------------------------------------------------------------------------------------
  logic [6:0]  len_reg;
  logic [3:0]  bound_reg;
  logic [31:0] mod_reg;
  logic [31:0] completions [0:MAX_LEN][0:COLS-1];
  bit          table_built;
  int unsigned seq_pos;
  int          balance;
  logic [31:0] rank_acc;
  bit          in_bound;

  function automatic int unsigned length_used();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return len_reg;
  endfunction

  function automatic int bound_used();
    if (bound_reg > MAX_BOUND) return MAX_BOUND;
    return int'(bound_reg);
  endfunction

  // A zero modulus stands for 2^32, so that counts simply wrap at 32 bits.
  function automatic logic [63:0] modulus_used();
    return (mod_reg == 0) ? 64'h1_0000_0000 : {32'd0, mod_reg};
  endfunction

  function automatic void restart_sequence();
    seq_pos  = 0;
    balance  = 0;
    rank_acc = '0;
    in_bound = 1'b1;
  endfunction

  // completions[len][b + k] holds how many ways len further symbols can follow from
  // balance b without leaving the bound, reduced by the modulus.
  function automatic void build_completions();
    int          k;
    int          cols;
    int unsigned n;
    logic [63:0] m;
    logic [63:0] s;
    k    = bound_used();
    cols = 2 * k + 1;
    n    = length_used();
    m    = modulus_used();
    for (int len = 0; len <= MAX_LEN; len++) begin
      for (int b = 0; b < COLS; b++) begin
        completions[len][b] = '0;
      end
    end
    for (int b = 0; b < cols; b++) begin
      completions[0][b] = 32'(64'd1 % m);
    end
    for (int len = 1; len <= n; len++) begin
      for (int b = 0; b < cols; b++) begin
        s = '0;
        if (b + 1 < cols) begin
          s += completions[len-1][b+1];
        end
        if (b >= 1) begin
          s += completions[len-1][b-1];
        end
        completions[len][b] = 32'(s % m);
      end
    end
    table_built = 1'b1;
  endfunction

  // Any write to a register in range forces a rebuild and drops the sequence in progress.
  function automatic void apply_register_write(input logic [1:0] idx, input logic [31:0] value);
    case (idx)
      REG_SEQ_LENGTH: begin
        len_reg = value[6:0];
      end
      REG_BALANCE_BOUND: begin
        bound_reg = value[3:0];
      end
      REG_MODULUS: begin
        mod_reg = value;
      end
      default: begin
        return;
      end
    endcase
    table_built = 1'b0;
    restart_sequence();
  endfunction

  // Takes one accepted symbol. An R adds every valid sequence that would have had an L at
  // this position; once the balance has left the bound nothing more is added.
  function automatic void rank_symbol(input logic sym);
    int unsigned n;
    int unsigned remaining;
    int          k;
    int          nb;
    logic [63:0] m;
    logic [63:0] r;
    if (!table_built) begin
      build_completions();
    end
    n = length_used();
    k = bound_used();
    m = modulus_used();
    if (seq_pos >= n) begin
      restart_sequence();
    end
    if (in_bound) begin
      if (sym == SYM_R) begin
        nb = balance + 1;
        if (nb <= k) begin
          remaining = n - seq_pos - 1;
          rank_acc  = 32'(({32'd0, rank_acc} + completions[remaining][nb + k]) % m);
        end
        balance--;
      end else begin
        balance++;
      end
      if (balance > k || balance < -k) begin
        in_bound = 1'b0;
      end
    end
    seq_pos++;
    if (seq_pos >= n) begin
      r = {32'd0, rank_acc};
      if (in_bound) begin
        r = (r + 1) % m;
      end
      owed_ranks.push_back('{rank: r[31:0], ok: in_bound});
      restart_sequence();
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Clock, and a watchdog that ends a run that has hung.
  // ---------------------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               owed_ranks.size());
      $display("bounded_balance_sequence_rank verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Driver. It works on the falling edge: a symbol on offer is held until its transfer has
  // happened, and only then is the next one taken from the queue or the valid dropped.
  // The receiver's stall is drawn afresh every cycle.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (rst_n && symbols_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid  <= 1'b1;
        in_symbol <= symbols_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. Both channels are sampled on the rising edge. The result is checked before the
  // symbol of the same edge is predicted, since a result never belongs to a symbol taken at
  // that very edge.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (owed_ranks.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("unexpected result transfer: rank %0d valid %0b", out_rank_count,
                     out_sequence_valid);
          end
        end else begin
          oldest_rank = owed_ranks.pop_front();
          results_seen++;
          if (out_rank_count !== oldest_rank.rank || out_sequence_valid !== oldest_rank.ok) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("result %0d mismatch: rank %0d valid %0b, expected rank %0d valid %0b",
                       results_seen, out_rank_count, out_sequence_valid, oldest_rank.rank,
                       oldest_rank.ok);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        rank_symbol(in_symbol);
        symbols_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------

  // Register write: a setup phase and then an access phase. The block must have finished any
  // table build first, and the next write waits for the build that this one starts.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    apply_register_write(idx, value);
    writes_done++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic queue_symbols(input string pattern);
    int i;
    for (i = 0; i < pattern.len(); i++) begin
      symbols_to_send.push_back((pattern[i] == "R") ? SYM_R : SYM_L);
      symbols_queued++;
    end
  endtask

  // A shaped sequence turns back at the bound and so stays valid, which is what lets the
  // rank reach its deeper table entries; an unshaped one is plain noise.
  task automatic queue_sequence(input int count, input bit shaped);
    int   k;
    int   level;
    logic sym;
    k     = bound_used();
    level = 0;
    repeat (count) begin
      if (shaped && level >= k) begin
        sym = SYM_R;
      end else if (shaped && level <= -k) begin
        sym = SYM_L;
      end else begin
        sym = logic'($urandom_range(0, 1));
      end
      level += (sym == SYM_R) ? -1 : 1;
      symbols_to_send.push_back(sym);
      symbols_queued++;
    end
  endtask

  // Waits until every symbol has been transferred and every owed result has arrived, then
  // waits out LATENCY_SLACK for the last lookup; a sequence may still be half taken.
  task automatic settle();
    while (symbols_to_send.size() != 0 || in_valid || owed_ranks.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    int          phase;
    int unsigned n;
    int          runs;
    bit          wrote;
    logic [31:0] value;

    len_reg     = 7'd64;
    bound_reg   = 4'd2;
    mod_reg     = 32'd1000000;
    table_built = 1'b0;
    restart_sequence();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Length three with bound one: a sequence that leaves the bound and then
    // takes a further symbol, two valid ones and an all-R one.
    write_register(REG_SEQ_LENGTH, 32'd3);
    write_register(REG_BALANCE_BOUND, 32'd1);
    write_register(REG_MODULUS, 32'd1000000);
    queue_symbols("LLRRLRLRLRRR");
    settle();

    // Bound zero: every single symbol leaves the bound at once.
    write_register(REG_SEQ_LENGTH, 32'd1);
    write_register(REG_BALANCE_BOUND, 32'd0);
    queue_symbols("LR");
    settle();

    // Zero length reads as one, the largest bound, and a unit modulus that forces rank zero.
    write_register(REG_SEQ_LENGTH, 32'd0);
    write_register(REG_BALANCE_BOUND, 32'd8);
    write_register(REG_MODULUS, 32'd1);
    queue_symbols("LR");
    settle();

    // A bound above the maximum clamps, and a zero modulus wraps at 32 bits.
    write_register(REG_SEQ_LENGTH, 32'd2);
    write_register(REG_BALANCE_BOUND, 32'd15);
    write_register(REG_MODULUS, 32'd0);
    queue_symbols("LRRR");
    settle();

    // A write past the last register, half way through a sequence, must not restart it.
    write_register(REG_SEQ_LENGTH, 32'd4);
    write_register(REG_BALANCE_BOUND, 32'd2);
    write_register(REG_MODULUS, 32'd7);
    queue_symbols("LR");
    settle();
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    queue_symbols("RL");
    settle();

    // Random part. The first phases pin the longest sequences (the reset setting, a length
    // above the maximum with a wrapping modulus, and an all-ones modulus); after that most
    // phases use short sequences so that results come often. Each phase ends with the sender
    // held back until nothing is owed, so every register write finds the block idle.
    phase = 0;
    while (symbols_queued < RANDOM_SYMBOLS + 24) begin
      if (phase == 0) begin
        write_register(REG_SEQ_LENGTH, 32'd64);
        write_register(REG_BALANCE_BOUND, 32'd2);
        write_register(REG_MODULUS, 32'd1000000);
      end else if (phase == 1) begin
        write_register(REG_SEQ_LENGTH, 32'd127);
        write_register(REG_BALANCE_BOUND, 32'd8);
        write_register(REG_MODULUS, 32'd0);
      end else if (phase == 2) begin
        write_register(REG_SEQ_LENGTH, 32'd100);
        write_register(REG_BALANCE_BOUND, 32'd7);
        write_register(REG_MODULUS, 32'hFFFF_FFFF);
      end else begin
        wrote = 1'b0;
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 19))
            0:       value = 32'd0;
            1:       value = $urandom_range(13, 127);
            default: value = $urandom_range(1, 12);
          endcase
          write_register(REG_SEQ_LENGTH, value);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1) == 0) begin
          value = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
          write_register(REG_BALANCE_BOUND, value);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 5))
            0:       value = $urandom;
            1:       value = $urandom_range(2, 50);
            2:       value = 32'd0;
            3:       value = 32'hFFFF_FFFF;
            4:       value = 32'd1;
            default: value = $urandom_range(1000, 1000000);
          endcase
          write_register(REG_MODULUS, value);
          wrote = 1'b1;
        end
        if (!wrote) begin
          write_register(REG_SEQ_LENGTH, $urandom_range(1, 12));
        end
      end
      n    = length_used();
      runs = (n <= 12) ? $urandom_range(2, 8) : $urandom_range(1, 2);
      repeat (runs) queue_sequence(n, $urandom_range(0, 3) != 0);
      // Now and then a sequence is left unfinished, to be dropped by the next write.
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        queue_sequence($urandom_range(1, n - 1), 1'b1);
      end
      settle();
      phase++;
    end

    settle();
    $display("Ran %0d symbol transfers giving %0d rank results across %0d register writes.",
             symbols_taken, results_seen, writes_done);
    $display("Lengths from one to the maximum, bounds from zero up, wrapping and unit moduli.");
    if (fault_count == 0) begin
      $display("bounded_balance_sequence_rank verification clean");
    end else begin
      $display("%0d faulty result transfers", fault_count);
      $display("bounded_balance_sequence_rank verification failed");
    end
    $finish;
  end

endmodule
